[hw/rtl/wdd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdd_pkg
// Shared types and constants of the window density despeckle unit.
// ----------------------------------------------------------------------------
package wdd_pkg;

  // Default geometry limits
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;
  localparam int unsigned MAX_RADIUS_DEF = 4;

  // Queue depths
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned RESQ_DEPTH = 4;

  // Configuration register indexes
  localparam logic [1:0] REG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_RADIUS    = 2'd2;
  localparam logic [1:0] REG_THRESHOLD = 2'd3;

  // Reset values
  localparam logic [10:0] WIDTH_RST     = 11'd1024;
  localparam logic [10:0] HEIGHT_RST    = 11'd1024;
  localparam logic [2:0]  RADIUS_RST    = 3'd1;
  localparam logic [7:0]  THRESHOLD_RST = 8'd255;

  // Item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [7:0] WHITE = 8'd255;

  // Classified request from front to back
  typedef struct packed {
    logic       kind;
    logic       dark;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cmd_t;

  // Result pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       removed;
    logic       frame_end;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_SCAN,
    BK_CENT,
    BK_FIN
  } back_state_e;

endpackage

[hw/rtl/window_density_despeckle_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_density_despeckle_unit
// Despeckle filter: whitens each pixel whose window holds few dark pixels.
//
//   channel   | direction | handshake          | payload
//   ----------+-----------+--------------------+-------------------------------
//   input     | in        | push / full        | kind_i, red_i, green_i, blue_i
//   result    | out       | pop / empty        | out_*_o, removed_o, frame_end_o
//   config    | in        | cfg_valid_i/ready_o| cfg_index_i, cfg_data_i
//
// A pixel request passes BK_IDLE and BK_CHECK; per result it releases, the
// engine makes (2r+1)^2 ring reads (clipped at frame edges) in BK_SCAN, r being
// the window radius, reads the centre in BK_CENT and pushes it in BK_FIN; the
// single-port line ring sets the pace. A flush releases at most one result.
// Reset clears counters and queues; the ring is not cleared. A full result queue
// stalls the window engine, but the input queue takes requests until it fills.
// ----------------------------------------------------------------------------
module window_density_despeckle_unit #(
  parameter int unsigned MAX_WIDTH  = wdd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = wdd_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned MAX_RADIUS = wdd_pkg::MAX_RADIUS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        kind_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic        removed_o,
  output logic        frame_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);
  import wdd_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RDW = $clog2(MAX_RADIUS + 1);

  logic [10:0]    width_q, height_q;
  logic [2:0]     radius_q;
  logic [7:0]     thr_q;
  logic           cfg_we, restart;
  logic [CW-1:0]  eff_w;
  logic [RW-1:0]  eff_h;
  logic [RDW-1:0] eff_r;

  logic cmd_valid, cmd_pop, res_full, res_push;
  cmd_t cmd;
  res_t res_in, res_out;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_we && (cfg_index_i != REG_THRESHOLD);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      radius_q <= RADIUS_RST;
      thr_q    <= THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_WIDTH:     width_q  <= cfg_data_i;
        REG_HEIGHT:    height_q <= cfg_data_i;
        REG_RADIUS:    radius_q <= cfg_data_i[2:0];
        REG_THRESHOLD: thr_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // saturated geometry
  always_comb begin
    eff_w = (width_q == '0) ? CW'(1)
          : (32'(width_q) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(width_q);
    eff_h = (height_q == '0) ? RW'(1)
          : (32'(height_q) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(height_q);
    eff_r = (32'(radius_q) > MAX_RADIUS) ? RDW'(MAX_RADIUS) : RDW'(radius_q);
  end

  wdd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .kind_i      (kind_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .threshold_i (thr_q),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  wdd_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS),
    .CW         (CW),
    .RW         (RW),
    .RDW        (RDW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .eff_w_i     (eff_w),
    .eff_h_i     (eff_h),
    .eff_r_i     (eff_r),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  wdd_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res_in),
    .res_full_o (res_full),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_out)
  );

  assign out_red_o   = res_out.red;
  assign out_green_o = res_out.green;
  assign out_blue_o  = res_out.blue;
  assign removed_o   = res_out.removed;
  assign frame_end_o = res_out.frame_end;

endmodule

[hw/rtl/wdd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdd_front
// Accepts input requests, marks dark pixels and queues them for the back end.
// ----------------------------------------------------------------------------
module wdd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic          kind_i,
  input  logic [7:0]    red_i,
  input  logic [7:0]    green_i,
  input  logic [7:0]    blue_i,
  input  logic [7:0]    threshold_i,
  output logic          cmd_valid_o,
  output wdd_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import wdd_pkg::*;

  localparam int unsigned PW = $clog2(CMDQ_DEPTH);
  localparam int unsigned NW = $clog2(CMDQ_DEPTH + 1);

  cmd_t            q_mem [CMDQ_DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;
  cmd_t            cmd_in;

  assign full        = (cnt_q == NW'(CMDQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  // classify the incoming request
  always_comb begin
    cmd_in.kind  = kind_i;
    cmd_in.dark  = (red_i <= threshold_i);
    cmd_in.red   = red_i;
    cmd_in.green = green_i;
    cmd_in.blue  = blue_i;
  end

  // pointer update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_q] <= cmd_in;
    end
  end

endmodule

[hw/rtl/wdd_outq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdd_outq
// Result queue between the window engine and the output side.
// ----------------------------------------------------------------------------
module wdd_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_push_i,
  input  wdd_pkg::res_t res_i,
  output logic          res_full_o,
  output logic          empty,
  input  logic          pop,
  output wdd_pkg::res_t res_o
);
  import wdd_pkg::*;

  localparam int unsigned PW = $clog2(RESQ_DEPTH);
  localparam int unsigned NW = $clog2(RESQ_DEPTH + 1);

  res_t          q_mem [RESQ_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign res_full_o = (cnt_q == NW'(RESQ_DEPTH));
  assign empty      = (cnt_q == '0);
  assign res_o      = q_mem[rd_q];
  assign do_push    = res_push_i && !res_full_o;
  assign do_pop     = pop && !empty;

  // pointer update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(RESQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(RESQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_q] <= res_i;
    end
  end

endmodule

[hw/rtl/wdd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdd_back
// Line ring and window engine: stores pixels, counts dark pixels per window
// one ring read per cycle and emits the filtered results.
// ----------------------------------------------------------------------------
module wdd_back #(
  parameter int unsigned MAX_WIDTH  = wdd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = wdd_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned MAX_RADIUS = wdd_pkg::MAX_RADIUS_DEF,
  parameter int unsigned CW         = $clog2(MAX_WIDTH + 1),
  parameter int unsigned RW         = $clog2(MAX_HEIGHT + 1),
  parameter int unsigned RDW        = $clog2(MAX_RADIUS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          restart_i,
  input  logic [CW-1:0] eff_w_i,
  input  logic [RW-1:0] eff_h_i,
  input  logic [RDW-1:0] eff_r_i,
  input  logic          cmd_valid_i,
  input  wdd_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output wdd_pkg::res_t res_o
);
  import wdd_pkg::*;

  localparam int unsigned RING  = 2 * MAX_RADIUS + 1;
  localparam int unsigned DEPTH = RING * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RIW   = $clog2(RING);
  localparam int unsigned CNTW  = $clog2(RING * RING + 1);
  localparam int unsigned NW    = $clog2(MAX_RADIUS + 2);
  localparam int unsigned EYW   = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);
  localparam int unsigned EXW   = $clog2(MAX_WIDTH + MAX_RADIUS + 1);
  localparam int unsigned DW    = 25;

  back_state_e state_q, state_d;

  logic [CW-1:0]   in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0]   in_row_q, in_row_d, out_row_q, out_row_d;
  logic [RIW-1:0]  in_ring_q, in_ring_d, out_ring_q, out_ring_d;
  logic [NW-1:0]   n_q, n_d, cap_q, cap_d;
  logic [CW-1:0]   x_q, x_d, x0_q, x0_d, x1_q, x1_d;
  logic [RW-1:0]   y_q, y_d, y1_q, y1_d;
  logic [RIW-1:0]  ring_q, ring_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            rd_v_q, rd_v_d;

  logic [DW-1:0]   mem [DEPTH];
  logic [DW-1:0]   rdata_q;
  logic            we, re;
  logic [AW-1:0]   waddr, raddr;

  // window geometry of the next output
  logic [EYW-1:0]  lr;
  logic [EXW-1:0]  lc;
  logic [RW-1:0]   y0;
  logic [CW-1:0]   x0;
  logic [RDW-1:0]  dy;
  logic [RIW:0]    ry0_ext;
  logic [RIW-1:0]  ry0;
  logic            ready, last_px, gone, is_pixel, in_frame;

  always_comb begin
    lr = (EYW'(out_row_q) + EYW'(eff_r_i) > EYW'(eff_h_i) - 1'b1)
         ? EYW'(eff_h_i) - 1'b1 : EYW'(out_row_q) + EYW'(eff_r_i);
    lc = (EXW'(out_col_q) + EXW'(eff_r_i) > EXW'(eff_w_i) - 1'b1)
         ? EXW'(eff_w_i) - 1'b1 : EXW'(out_col_q) + EXW'(eff_r_i);
    ready = (out_row_q < eff_h_i) &&
            ((EYW'(in_row_q) > lr) ||
             ((EYW'(in_row_q) == lr) && (EXW'(in_col_q) > lc)));
    y0 = (out_row_q >= RW'(eff_r_i)) ? out_row_q - RW'(eff_r_i) : '0;
    x0 = (out_col_q >= CW'(eff_r_i)) ? out_col_q - CW'(eff_r_i) : '0;
    dy = RDW'(out_row_q - y0);
    ry0_ext = ((RIW+1)'(out_ring_q) >= (RIW+1)'(dy))
              ? (RIW+1)'(out_ring_q) - (RIW+1)'(dy)
              : (RIW+1)'(out_ring_q) + (RIW+1)'(RING) - (RIW+1)'(dy);
    ry0 = ry0_ext[RIW-1:0];
    last_px = (out_row_q == eff_h_i - 1'b1) && (out_col_q == eff_w_i - 1'b1);
    gone = (cnt_q <= CNTW'({eff_r_i, 1'b0}));
    is_pixel = (cmd_i.kind == KIND_PIXEL);
    in_frame = (in_row_q < eff_h_i);
  end

  // result fields
  always_comb begin
    res_o.red       = gone ? WHITE : rdata_q[23:16];
    res_o.green     = gone ? WHITE : rdata_q[15:8];
    res_o.blue      = gone ? WHITE : rdata_q[7:0];
    res_o.removed   = gone;
    res_o.frame_end = last_px;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && (!is_pixel || in_frame)) begin
          state_d = BK_CHECK;
        end
      end
      BK_CHECK: begin
        state_d = (n_q < cap_q && ready) ? BK_SCAN : BK_IDLE;
      end
      BK_SCAN: begin
        if (x_q == x1_q && y_q == y1_q) begin
          state_d = BK_CENT;
        end
      end
      BK_CENT: state_d = BK_FIN;
      BK_FIN: begin
        if (!res_full_i) begin
          state_d = BK_CHECK;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_ring_d  = in_ring_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_ring_d = out_ring_q;
    n_d        = n_q;
    cap_d      = cap_q;
    x_d        = x_q;
    y_d        = y_q;
    x0_d       = x0_q;
    x1_d       = x1_q;
    y1_d       = y1_q;
    ring_d     = ring_q;
    rd_v_d     = 1'b0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = AW'(in_ring_q) * AW'(MAX_WIDTH) + AW'(in_col_q);
    raddr      = AW'(ring_q) * AW'(MAX_WIDTH) + AW'(x_q);
    // dark pixels of the read that returned this cycle
    cnt_d      = cnt_q + CNTW'(rd_v_q & rdata_q[24]);
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          n_d       = '0;
          if (!is_pixel) begin
            cap_d = NW'(1);
          end else if (in_frame) begin
            we    = 1'b1;
            cap_d = NW'(eff_r_i) + 1'b1;
            if (in_col_q + 1'b1 >= eff_w_i) begin
              in_col_d  = '0;
              in_row_d  = in_row_q + 1'b1;
              in_ring_d = (in_ring_q == RIW'(RING - 1)) ? '0 : in_ring_q + 1'b1;
            end else begin
              in_col_d = in_col_q + 1'b1;
            end
          end
        end
      end
      BK_CHECK: begin
        x_d    = x0;
        x0_d   = x0;
        x1_d   = CW'(lc);
        y_d    = y0;
        y1_d   = RW'(lr);
        ring_d = ry0;
        cnt_d  = '0;
      end
      BK_SCAN: begin
        re     = 1'b1;
        rd_v_d = 1'b1;
        if (x_q == x1_q) begin
          x_d = x0_q;
          if (y_q != y1_q) begin
            y_d    = y_q + 1'b1;
            ring_d = (ring_q == RIW'(RING - 1)) ? '0 : ring_q + 1'b1;
          end
        end else begin
          x_d = x_q + 1'b1;
        end
      end
      BK_CENT: begin
        // center pixel colour
        re    = 1'b1;
        raddr = AW'(out_ring_q) * AW'(MAX_WIDTH) + AW'(out_col_q);
      end
      BK_FIN: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          n_d        = n_q + 1'b1;
          if (last_px) begin
            in_col_d   = '0;
            in_row_d   = '0;
            in_ring_d  = '0;
            out_col_d  = '0;
            out_row_d  = '0;
            out_ring_d = '0;
          end else if (out_col_q + 1'b1 >= eff_w_i) begin
            out_col_d  = '0;
            out_row_d  = out_row_q + 1'b1;
            out_ring_d = (out_ring_q == RIW'(RING - 1)) ? '0 : out_ring_q + 1'b1;
          end else begin
            out_col_d = out_col_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
    // geometry write restarts the frame
    if (restart_i) begin
      in_col_d   = '0;
      in_row_d   = '0;
      in_ring_d  = '0;
      out_col_d  = '0;
      out_row_d  = '0;
      out_ring_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_ring_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_ring_q <= '0;
      n_q        <= '0;
      cap_q      <= '0;
      rd_v_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_ring_q  <= in_ring_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_ring_q <= out_ring_d;
      n_q        <= n_d;
      cap_q      <= cap_d;
      rd_v_q     <= rd_v_d;
    end
  end

  // scan registers
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    x0_q   <= x0_d;
    x1_q   <= x1_d;
    y1_q   <= y1_d;
    ring_q <= ring_d;
    cnt_q  <= cnt_d;
  end

  // line ring: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= {cmd_i.dark, cmd_i.red, cmd_i.green, cmd_i.blue};
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

endmodule
